[src/sac_pkg.sv]
// Shared types and constants for the sphere versus box classifier.
package sac_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_Z   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RADIUS     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHECK_CONT = 3'd4;

   // Relation codes
   localparam int unsigned REL_BITS = 2;

   localparam logic [REL_BITS-1:0] REL_OUTSIDE   = 2'h0;
   localparam logic [REL_BITS-1:0] REL_INTERSECT = 2'h1;
   localparam logic [REL_BITS-1:0] REL_CONTAINED = 2'h2;

   // Load enables for the per-axis pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

endpackage

[src/sac_axis.sv]
// One axis of the classifier: corner distances, clamp distance and their squares.
module sac_axis #(
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                        clock,
   input  sac_pkg::stage_en_type       stage_en,
   input  logic signed [COORD_BITS-1:0] centre,
   input  logic signed [COORD_BITS-1:0] box_low,
   input  logic signed [COORD_BITS-1:0] box_high,
   output logic [2*COORD_BITS-1:0]     far_sq,
   output logic [2*COORD_BITS-1:0]     near_sq
);
   import sac_pkg::*;

   localparam int unsigned SQ_BITS = 2 * COORD_BITS;

   logic signed [COORD_BITS:0] diff_lo;
   logic signed [COORD_BITS:0] diff_hi;
   logic [COORD_BITS-1:0]      abs_lo;
   logic [COORD_BITS-1:0]      abs_hi;
   logic                       le_lo;
   logic                       ge_hi;

   logic [COORD_BITS-1:0] far_in;
   logic [COORD_BITS-1:0] far_ff;
   logic [COORD_BITS-1:0] near_in;
   logic [COORD_BITS-1:0] near_ff;
   logic [SQ_BITS-1:0]    far_sq_in;
   logic [SQ_BITS-1:0]    far_sq_ff;
   logic [SQ_BITS-1:0]    near_sq_in;
   logic [SQ_BITS-1:0]    near_sq_ff;

   // Stage 1: signed distances to both planes, magnitudes fit in COORD_BITS
   always_comb begin
      diff_lo = {centre[COORD_BITS-1], centre} - {box_low[COORD_BITS-1], box_low};
      diff_hi = {centre[COORD_BITS-1], centre} - {box_high[COORD_BITS-1], box_high};
      abs_lo  = diff_lo[COORD_BITS] ? COORD_BITS'(-diff_lo) : diff_lo[COORD_BITS-1:0];
      abs_hi  = diff_hi[COORD_BITS] ? COORD_BITS'(-diff_hi) : diff_hi[COORD_BITS-1:0];
      le_lo   = (centre <= box_low);
      ge_hi   = (centre >= box_high);
   end

   // Farthest corner on this axis; clamp distance with the lower plane winning
   always_comb begin
      far_in = (abs_lo >= abs_hi) ? abs_lo : abs_hi;
      if (le_lo) begin
         near_in = abs_lo;
      end else if (ge_hi) begin
         near_in = abs_hi;
      end else begin
         near_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         far_ff  <= far_in;
         near_ff <= near_in;
      end
   end

   // Stage 2: squares
   assign far_sq_in  = SQ_BITS'(far_ff) * SQ_BITS'(far_ff);
   assign near_sq_in = SQ_BITS'(near_ff) * SQ_BITS'(near_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         far_sq_ff  <= far_sq_in;
         near_sq_ff <= near_sq_in;
      end
   end

   assign far_sq  = far_sq_ff;
   assign near_sq = near_sq_ff;

endmodule

[src/sphere_aabb_classify.sv]
// Top level of the sphere versus axis-aligned box classifier.
//
// Usage: the sphere (centre, radius) and the containment enable are set through
// the csr_ write port while the block is idle. Each req_ beat carries one box as
// lower and upper corners; each rsp_ beat returns its relation: outside,
// intersecting, or contained when the containment test is on.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Throughput: one box per clock cycle, sustained while rsp_stall is low.
// A box passes the four pipeline stages in order (plane distances, squares,
// three-axis sums, compare into the output register) before rsp_valid rises.
// Stall: each full stage holds while the one after it is full and held, so
// behind a stalled rsp_ beat the empty stages fill and then hold; req_stall
// rises only when all four stages are full and the output is stalled.
// Reset: the pipeline empties, centre returns to the origin, radius to 50000
// (cut to the radius width) and containment checking is enabled.
module sphere_aabb_classify #(
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [sac_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata,
   // box requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_BITS-1:0]        req_box_low_x,
   input  logic signed [COORD_BITS-1:0]        req_box_low_y,
   input  logic signed [COORD_BITS-1:0]        req_box_low_z,
   input  logic signed [COORD_BITS-1:0]        req_box_high_x,
   input  logic signed [COORD_BITS-1:0]        req_box_high_y,
   input  logic signed [COORD_BITS-1:0]        req_box_high_z,
   // relations
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sac_pkg::REL_BITS-1:0]        rsp_relation
);
   import sac_pkg::*;

   localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
   localparam int unsigned SUM_BITS = SQ_BITS + 2;
   localparam int unsigned RAD_BITS = COORD_BITS - 1;
   localparam int unsigned R2_BITS  = 2 * RAD_BITS;
   localparam logic [RAD_BITS-1:0] RADIUS_RST = RAD_BITS'(50000);

   // configuration registers
   logic signed [COORD_BITS-1:0] centre_x_ff;
   logic signed [COORD_BITS-1:0] centre_y_ff;
   logic signed [COORD_BITS-1:0] centre_z_ff;
   logic [RAD_BITS-1:0]          radius_ff;
   logic                         check_ff;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   stage_en_type axis_en;

   // datapath
   logic [SQ_BITS-1:0]  far_sq_x, far_sq_y, far_sq_z;
   logic [SQ_BITS-1:0]  near_sq_x, near_sq_y, near_sq_z;
   logic [R2_BITS-1:0]  r2_in;
   logic [R2_BITS-1:0]  r2_ff;
   logic [R2_BITS-1:0]  r2_s3_ff;
   logic [SUM_BITS-1:0] sum_far_in;
   logic [SUM_BITS-1:0] sum_far_ff;
   logic [SUM_BITS-1:0] sum_near_in;
   logic [SUM_BITS-1:0] sum_near_ff;
   logic [SUM_BITS-1:0] r2_wide;
   logic [REL_BITS-1:0] rel_in;
   logic [REL_BITS-1:0] rel_ff;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         centre_z_ff <= '0;
         radius_ff   <= RADIUS_RST;
         check_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CENTRE_X:   centre_x_ff <= csr_wdata;
            REG_CENTRE_Y:   centre_y_ff <= csr_wdata;
            REG_CENTRE_Z:   centre_z_ff <= csr_wdata;
            REG_RADIUS:     radius_ff   <= csr_wdata[RAD_BITS-1:0];
            REG_CHECK_CONT: check_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when its successor moves on
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall  = !en1;
   assign axis_en.s1 = en1;
   assign axis_en.s2 = en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stages 1 and 2, one unit per axis
   sac_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock    (clock),
      .stage_en (axis_en),
      .centre   (centre_x_ff),
      .box_low  (req_box_low_x),
      .box_high (req_box_high_x),
      .far_sq   (far_sq_x),
      .near_sq  (near_sq_x)
   );

   sac_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock    (clock),
      .stage_en (axis_en),
      .centre   (centre_y_ff),
      .box_low  (req_box_low_y),
      .box_high (req_box_high_y),
      .far_sq   (far_sq_y),
      .near_sq  (near_sq_y)
   );

   sac_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
      .clock    (clock),
      .stage_en (axis_en),
      .centre   (centre_z_ff),
      .box_low  (req_box_low_z),
      .box_high (req_box_high_z),
      .far_sq   (far_sq_z),
      .near_sq  (near_sq_z)
   );

   // radius squared, kept in step with the squares
   assign r2_in = R2_BITS'(radius_ff) * R2_BITS'(radius_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         r2_ff <= r2_in;
      end
   end

   // stage 3: exact three-axis sums; the worst corner is the sum of per-axis maxima
   assign sum_far_in  = SUM_BITS'(far_sq_x) + SUM_BITS'(far_sq_y) + SUM_BITS'(far_sq_z);
   assign sum_near_in = SUM_BITS'(near_sq_x) + SUM_BITS'(near_sq_y) + SUM_BITS'(near_sq_z);

   always_ff @(posedge clock) begin
      if (en3) begin
         sum_far_ff  <= sum_far_in;
         sum_near_ff <= sum_near_in;
         r2_s3_ff    <= r2_ff;
      end
   end

   // stage 4: compare into the output register
   assign r2_wide = SUM_BITS'(r2_s3_ff);

   always_comb begin
      if (check_ff && (sum_far_ff <= r2_wide)) begin
         rel_in = REL_CONTAINED;
      end else if (sum_near_ff < r2_wide) begin
         rel_in = REL_INTERSECT;
      end else begin
         rel_in = REL_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rel_ff <= rel_in;
      end
   end

   assign rsp_valid    = v4_ff;
   assign rsp_relation = rel_ff;

`ifndef SYNTH
   // input is only held off when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("req_stall with an empty pipeline stage");

   // a held output keeps the stage behind it occupied
   a_hold_s3: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp_stall && v3_ff) |=> v3_ff)
      else $error("stage 3 beat lost behind a stalled output");

   // contained only reported with containment checking on
   a_contained_en: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_relation == REL_CONTAINED)) |-> check_ff)
      else $error("contained relation with checking disabled");

   // no undefined relation code leaves the block
   a_rel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_relation == REL_OUTSIDE || rsp_relation == REL_INTERSECT ||
                     rsp_relation == REL_CONTAINED))
      else $error("undefined relation code");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
`endif

endmodule
